// ===== rtl/lds_pkg.sv =====
package lds_pkg;

  // input item and result item
  typedef struct packed {
    logic signed [15:0] log_prob;
    logic        [15:0] uniform_draw;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic [5:0] sampled_index;
    logic       capacity_exceeded;
  } result_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LSE,
    S_RD,
    S_DIFF,
    S_TERM,
    S_ACC
  } state_t;

  // quarter-step segments covered by each table
  localparam int SP_SEGS = 64;
  localparam int EX_SEGS = 48;

  // round(256*ln(1+e^-x)), x = 0, 0.25, ..., 16
  localparam logic [16:0] SP_TAB [65] = '{
    0: 17'd177, 1: 17'd147, 2: 17'd121, 3: 17'd99, 4: 17'd80, 5: 17'd64,
    6: 17'd52, 7: 17'd41, 8: 17'd32, 9: 17'd26, 10: 17'd20, 11: 17'd16,
    12: 17'd12, 13: 17'd10, 14: 17'd8, 15: 17'd6, 16: 17'd5, 17: 17'd4,
    18: 17'd3, 19: 17'd2, 20: 17'd2, 21: 17'd1, 22: 17'd1, 23: 17'd1,
    24: 17'd1, default: 17'd0
  };

  // round(65536*e^-x), x = 0, 0.25, ..., 12
  localparam logic [16:0] EX_TAB [49] = '{
    17'd65536, 17'd51039, 17'd39750, 17'd30957, 17'd24109, 17'd18776,
    17'd14623, 17'd11388, 17'd8869, 17'd6907, 17'd5380, 17'd4190,
    17'd3263, 17'd2541, 17'd1979, 17'd1541, 17'd1200, 17'd935,
    17'd728, 17'd567, 17'd442, 17'd344, 17'd268, 17'd209,
    17'd162, 17'd127, 17'd99, 17'd77, 17'd60, 17'd47,
    17'd36, 17'd28, 17'd22, 17'd17, 17'd13, 17'd10,
    17'd8, 17'd6, 17'd5, 17'd4, 17'd3, 17'd2,
    17'd2, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1,
    17'd0
  };

  // linear interpolation in a decreasing quarter-step table, zero past its end
  function automatic logic [16:0] lut_interp(input logic use_exp, input logic [15:0] d);
    logic [9:0]  seg;
    logic [5:0]  frac;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [22:0] prod;
    logic [16:0] res;
    seg  = d[15:6];
    frac = d[5:0];
    t0   = '0;
    t1   = '0;
    res  = '0;
    if (use_exp) begin
      if (seg < 10'(EX_SEGS)) begin
        t0 = EX_TAB[seg[5:0]];
        t1 = EX_TAB[seg[5:0] + 6'd1];
      end
    end else begin
      if (seg < 10'(SP_SEGS)) begin
        t0 = SP_TAB[seg[6:0]];
        t1 = SP_TAB[seg[6:0] + 7'd1];
      end
    end
    prod = 23'(t0 - t1) * 23'(frac) + 23'd32;
    res  = t0 - 17'(prod >> 6);
    return res;
  endfunction

endpackage

// ===== rtl/log_domain_categorical_sampler.sv =====
// Log-domain categorical sampler. Feed one item per entry: a signed Q8.8
// unnormalized log probability. Pulse start while busy is low; the item is
// taken on that edge. Each entry is written to an on-chip store and folded
// into a running log-sum-exp (max plus an interpolated softplus table). The
// first entry of a run and any dropped entry need no further step; every
// other entry adds a softplus step on the shared table-interpolation unit.
// The item flagged last_item also carries a Q0.16 uniform draw and starts
// the sampling pass: the store is walked from entry 0, each entry taking a
// store read, the difference to the log sum, an exp table step on the same
// shared unit, and an accumulate and compare. The result (chosen index, low
// 6 bits, and a capacity flag) is shown for exactly one cycle with done high;
// the receiver cannot stall it, so it must take it then. Items past
// MAX_ENTRIES are dropped and reported through capacity_exceeded. The block
// clears its run state after every result. The store needs no clearing: only
// entries written in the current run are read.
module log_domain_categorical_sampler import lds_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_item_t item,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  localparam int IDXW = $clog2(MAX_ENTRIES);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);

  // control state
  state_t            state, state_next;
  logic [CNTW-1:0]   count, count_next;
  logic              overflow, overflow_next;
  logic              pend_last, pend_last_next;
  logic              done_next;

  // run data
  logic signed [15:0] total, total_next;
  logic        [15:0] draw, draw_next;
  logic signed [15:0] hi, hi_next;
  logic        [15:0] dval, dval_next;
  logic        [16:0] term, term_next;
  logic        [16:0] acc, acc_next;
  logic [IDXW-1:0]    ptr, ptr_next;
  result_t            result_next;

  // store port
  logic              ram_we;
  logic [IDXW-1:0]   ram_waddr;
  logic [15:0]       ram_rdata;

  // shared interpolation unit
  logic              unit_exp;
  logic [16:0]       unit_out;

  // datapath helpers
  logic              accept;
  logic signed [16:0] in_diff;
  logic signed [16:0] rd_diff;
  logic signed [17:0] lse_sum;
  logic [16:0]       acc_sum;
  logic              at_end;

  lds_ram #(
    .WIDTH (16),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.log_prob),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // softplus in the update step, exp in the sampling pass
  assign unit_exp = (state != S_LSE);
  assign unit_out = lut_interp(unit_exp, dval);

  assign in_diff = 17'(total) - 17'(item.log_prob);
  assign rd_diff = 17'(total) - 17'($signed(ram_rdata));
  assign lse_sum = 18'(hi) + 18'(unit_out);
  assign acc_sum = acc + term;
  assign at_end  = (CNTW'(ptr) == count - CNTW'(1));

  assign ram_waddr = count[IDXW-1:0];

  always_comb begin
    state_next     = state;
    count_next     = count;
    overflow_next  = overflow;
    pend_last_next = pend_last;
    done_next      = 1'b0;
    total_next     = total;
    draw_next      = draw;
    hi_next        = hi;
    dval_next      = dval;
    term_next      = term;
    acc_next       = acc;
    ptr_next       = ptr;
    result_next    = result;
    ram_we         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          draw_next      = item.uniform_draw;
          pend_last_next = item.last_item;
          acc_next       = '0;
          ptr_next       = '0;
          if (count < CNTW'(MAX_ENTRIES)) begin
            ram_we     = 1'b1;
            count_next = count + CNTW'(1);
            if (count == '0) begin
              // first entry: the log sum is the entry itself
              total_next = item.log_prob;
              if (item.last_item) begin
                state_next = S_RD;
              end
            end else begin
              // larger operand and magnitude of the difference
              if (in_diff < 0) begin
                hi_next   = item.log_prob;
                dval_next = 16'(-in_diff);
              end else begin
                hi_next   = total;
                dval_next = in_diff[15:0];
              end
              state_next = S_LSE;
            end
          end else begin
            // store full: drop the entry, keep sampling if it ends the run
            overflow_next = 1'b1;
            if (item.last_item) begin
              state_next = S_RD;
            end
          end
        end
      end

      S_LSE: begin
        // max plus softplus, saturated at the top of Q8.8
        if (lse_sum > 18'sd32767) begin
          total_next = 16'sh7FFF;
        end else begin
          total_next = lse_sum[15:0];
        end
        state_next = pend_last ? S_RD : S_IDLE;
      end

      S_RD: begin
        // store read in flight for entry ptr
        state_next = S_DIFF;
      end

      S_DIFF: begin
        // entries above the log sum count as a whole unit
        dval_next  = (rd_diff < 0) ? 16'd0 : rd_diff[15:0];
        state_next = S_TERM;
      end

      S_TERM: begin
        term_next  = unit_out;
        state_next = S_ACC;
      end

      S_ACC: begin
        acc_next = acc_sum;
        if (acc_sum > 17'(draw) || at_end) begin
          // first crossing, or clamp to the last stored entry
          result_next.sampled_index     = 6'(ptr);
          result_next.capacity_exceeded = overflow;
          done_next      = 1'b1;
          count_next     = '0;
          total_next     = '0;
          overflow_next  = 1'b0;
          pend_last_next = 1'b0;
          state_next     = S_IDLE;
        end else begin
          ptr_next   = ptr + IDXW'(1);
          state_next = S_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      overflow  <= 1'b0;
      pend_last <= 1'b0;
      done      <= 1'b0;
      total     <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      overflow  <= overflow_next;
      pend_last <= pend_last_next;
      done      <= done_next;
      total     <= total_next;
    end
    draw   <= draw_next;
    hi     <= hi_next;
    dval   <= dval_next;
    term   <= term_next;
    acc    <= acc_next;
    ptr    <= ptr_next;
    result <= result_next;
  end

  // a result only follows an accumulate step
  a_done_after_acc: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_ACC)
    else $error("result strobe without accumulate step");

  // run state is cleared together with the result
  a_clear_on_done: assert property (@(posedge clk) disable iff (rst)
    done |-> (count == '0) && !overflow && (total == '0))
    else $error("run state not cleared with result");

  // the fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  // the walk stops at the first crossing, so the total so far stays at or below the draw
  a_acc_below_draw: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> acc <= 17'(draw))
    else $error("walk continued past the draw");

  // the walk only visits stored entries
  a_ptr_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_DIFF || state == S_TERM || state == S_ACC)
      |-> CNTW'(ptr) < count)
    else $error("store read beyond stored entries");

endmodule

// ===== rtl/lds_ram.sv =====
module lds_ram import lds_pkg::*; #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench import lds_pkg::*;;

  localparam int CAPACITY = 64;

  // softplus table, round(256*ln(1+e^-x)) at quarter steps, zero from entry 25 on
  localparam int SOFTPLUS_Q8 [65] = '{
    0: 177, 1: 147, 2: 121, 3: 99, 4: 80, 5: 64, 6: 52, 7: 41,
    8: 32, 9: 26, 10: 20, 11: 16, 12: 12, 13: 10, 14: 8, 15: 6,
    16: 5, 17: 4, 18: 3, 19: 2, 20: 2, 21: 1, 22: 1, 23: 1,
    24: 1, default: 0
  };

  // exp table, round(65536*e^-x) at quarter steps
  localparam int EXP_Q16 [49] = '{
    65536, 51039, 39750, 30957, 24109, 18776, 14623, 11388,
    8869, 6907, 5380, 4190, 3263, 2541, 1979, 1541,
    1200, 935, 728, 567, 442, 344, 268, 209,
    162, 127, 99, 77, 60, 47, 36, 28,
    22, 17, 13, 10, 8, 6, 5, 4,
    3, 2, 2, 1, 1, 1, 1, 1,
    0
  };

  logic     clk;
  logic     rst;
  logic     start;
  in_item_t item;
  logic     busy;
  logic     done;
  result_t  result;

  log_domain_categorical_sampler #(.MAX_ENTRIES(CAPACITY)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // directed stimulus: one item per row, typed result where it is obvious
  typedef struct {
    in_item_t it;
    bit       fixed;
    result_t  want;
  } probe_row_t;

  localparam int PROBE_ROWS = 23;

  probe_row_t probe_rows [PROBE_ROWS] = '{
    // single entry runs always pick entry 0
    '{'{16'h0000, 16'h0000, 1'b1}, 1'b1, '{6'd0, 1'b0}},
    '{'{16'h8000, 16'hFFFF, 1'b1}, 1'b1, '{6'd0, 1'b0}},
    '{'{16'h7FFF, 16'h5555, 1'b1}, 1'b1, '{6'd0, 1'b0}},
    // log sum saturates at the top, both terms are 1.0
    '{'{16'h7FFF, 16'hAAAA, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'h7FFF, 16'hAAAA, 1'b1}, 1'b1, '{6'd0, 1'b0}},
    // most negative then most positive: first term is zero, draw zero
    '{'{16'h8000, 16'h1234, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'h7FFF, 16'h0000, 1'b1}, 1'b1, '{6'd1, 1'b0}},
    // two equal entries, full draw
    '{'{16'h0000, 16'h0000, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'h0000, 16'hFFFF, 1'b1}, 1'b0, '{6'd0, 1'b0}},
    // +1.0 and -1.0
    '{'{16'h0100, 16'hC3A5, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'hFF00, 16'h8000, 1'b1}, 1'b0, '{6'd0, 1'b0}},
    // eight equal entries against a full draw, where rounding may fall short
    '{'{16'hFF9C, 16'h0F0F, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'hFF9C, 16'hF0F0, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'hFF9C, 16'h0F0F, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'hFF9C, 16'hF0F0, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'hFF9C, 16'h0F0F, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'hFF9C, 16'hF0F0, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'hFF9C, 16'h0F0F, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'hFF9C, 16'hFFFF, 1'b1}, 1'b0, '{6'd0, 1'b0}},
    // difference exactly at the end of the softplus table
    '{'{16'h1000, 16'h0000, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'h0000, 16'h0001, 1'b1}, 1'b0, '{6'd0, 1'b0}},
    // difference exactly at the end of the exp table
    '{'{16'h0000, 16'h0000, 1'b0}, 1'b0, '{6'd0, 1'b0}},
    '{'{16'h0C00, 16'h7FFF, 1'b1}, 1'b0, '{6'd0, 1'b0}}
  };

  // predictor state: the stored run and its log-sum-exp
  int  entry_log [CAPACITY];
  int  stored_count;
  int  log_total;
  bit  dropped_any;

  result_t expected_picks [$];
  result_t front_pick;

  int  failures;
  int  items_sent;
  int  runs_sent;
  int  picks_checked;
  int  overflow_runs;
  bit  gaps_on;

  // interpolated lookup in a decreasing quarter-step table, zero past its end
  function automatic int quarter_lookup(input bit is_exp, input int d);
    int seg;
    int frac;
    int a;
    int b;
    seg  = d >> 6;
    frac = d & 63;
    if (seg >= (is_exp ? 48 : 64)) return 0;
    a = is_exp ? EXP_Q16[seg] : SOFTPLUS_Q8[seg];
    b = is_exp ? EXP_Q16[seg + 1] : SOFTPLUS_Q8[seg + 1];
    return a - (((a - b) * frac + 32) >> 6);
  endfunction

  // fold one item into the run; on the last item walk the store and pick
  function automatic bit sample_step(input in_item_t it, output result_t pick);
    int x;
    int hi;
    int d;
    int sum;
    int acc;
    int chosen;
    int i;
    x    = int'($signed(it.log_prob));
    pick = '0;
    if (stored_count < CAPACITY) begin
      entry_log[stored_count] = x;
      if (stored_count == 0) begin
        log_total = x;
      end else begin
        hi  = (log_total > x) ? log_total : x;
        d   = (log_total > x) ? log_total - x : x - log_total;
        sum = hi + quarter_lookup(1'b0, d);
        log_total = (sum > 32767) ? 32767 : sum;
      end
      stored_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (!it.last_item) return 1'b0;

    // clamp to the last stored entry if the total never exceeds the draw
    chosen = stored_count - 1;
    acc    = 0;
    for (i = 0; i < stored_count; i++) begin
      d = log_total - entry_log[i];
      if (d < 0) d = 0;
      acc += quarter_lookup(1'b1, d);
      if (acc > int'(it.uniform_draw)) begin
        chosen = i;
        break;
      end
    end
    pick.sampled_index     = chosen[5:0];
    pick.capacity_exceeded = dropped_any;
    stored_count = 0;
    log_total    = 0;
    dropped_any  = 1'b0;
    return 1'b1;
  endfunction

  // hold start until the block takes the item, then maybe idle a while
  task automatic issue_entry(input in_item_t it, input bit fixed, input result_t want);
    result_t guess;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (sample_step(it, guess)) begin
      expected_picks.push_back(fixed ? want : guess);
      runs_sent++;
      if (guess.capacity_exceeded) overflow_runs++;
    end
    items_sent++;
    if (gaps_on && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result checker: every strobe must match the oldest expected pick
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_picks.size() == 0) begin
        $display("%0t: unexpected result, index %0d capacity_exceeded %0b",
                 $time, result.sampled_index, result.capacity_exceeded);
        failures++;
      end else begin
        front_pick = expected_picks.pop_front();
        picks_checked++;
        if (result.sampled_index !== front_pick.sampled_index) begin
          $display("%0t: sampled_index expected %0d actual %0d",
                   $time, front_pick.sampled_index, result.sampled_index);
          failures++;
        end
        if (result.capacity_exceeded !== front_pick.capacity_exceeded) begin
          $display("%0t: capacity_exceeded expected %0b actual %0b",
                   $time, front_pick.capacity_exceeded, result.capacity_exceeded);
          failures++;
        end
      end
    end
  end

  // stimulus
  initial begin
    in_item_t it;
    result_t  none;
    int       run_len;
    int       mode;
    int       base;
    int       run_draw;
    int       random_items;
    int       k;
    int       waited;

    rst           = 1'b1;
    start         = 1'b0;
    item          = '0;
    none          = '0;
    failures      = 0;
    items_sent    = 0;
    runs_sent     = 0;
    picks_checked = 0;
    overflow_runs = 0;
    stored_count  = 0;
    log_total     = 0;
    dropped_any   = 1'b0;
    gaps_on       = 1'b1;
    random_items  = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    for (k = 0; k < PROBE_ROWS; k++)
      issue_entry(probe_rows[k].it, probe_rows[k].fixed, probe_rows[k].want);

    // random runs: mostly short, some long, a few past capacity
    while (random_items < 600) begin
      // a long stretch in the middle runs with no gaps at all
      gaps_on = !(random_items >= 250 && random_items < 400);
      k = $urandom_range(99);
      if (k < 60)      run_len = $urandom_range(6, 1);
      else if (k < 90) run_len = $urandom_range(40, 7);
      else if (k < 96) run_len = $urandom_range(64, 41);
      else             run_len = $urandom_range(CAPACITY + 8, CAPACITY + 1);
      mode = $urandom_range(3);
      base = $urandom_range(8192) - 4096;
      k = $urandom_range(9);
      run_draw = (k == 0) ? 0 : (k == 1) ? 65535 : $urandom_range(65535);
      for (k = 0; k < run_len; k++) begin
        case (mode)
          0: it.log_prob = 16'($urandom);
          1: it.log_prob = 16'(base + $urandom_range(512) - 256);
          2: it.log_prob = 16'(base + $urandom_range(4096) - 2048);
          default: it.log_prob = 16'(base);
        endcase
        it.last_item    = (k == run_len - 1);
        it.uniform_draw = it.last_item ? 16'(run_draw) : 16'($urandom);
        issue_entry(it, 1'b0, none);
        random_items++;
      end
    end
    start <= 1'b0;

    // drain: wait for the slowest run to deliver its result
    waited = 0;
    while (expected_picks.size() != 0 && waited < 8 * CAPACITY + 100) begin
      @(posedge clk);
      waited++;
    end
    if (expected_picks.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_picks.size());
      failures += expected_picks.size();
    end
    repeat (4 * CAPACITY + 8) @(posedge clk);

    $display("%0d items in %0d runs, %0d of them past capacity; %0d picks compared",
             items_sent, runs_sent, overflow_runs, picks_checked);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
